FILE: rtl/ppts_pkg.sv
`default_nettype none
package ppts_pkg;

	localparam int CLIP_W = 50;
	localparam int NUM_W = 51;
	localparam int PROD_W = 67;
	localparam int DIV_BITS = 41;
	localparam int LANE_LAT = DIV_BITS + 5;

	localparam logic [2:0] REG_COEF_X_FIRST = 3'd0;
	localparam logic [2:0] REG_COEF_X_SECOND = 3'd1;
	localparam logic [2:0] REG_COEF_Y_FIRST = 3'd2;
	localparam logic [2:0] REG_COEF_Y_SECOND = 3'd3;
	localparam logic [2:0] REG_COEF_W_FIRST = 3'd4;
	localparam logic [2:0] REG_COEF_W_SECOND = 3'd5;
	localparam logic [2:0] REG_VP_ORIGIN = 3'd6;
	localparam logic [2:0] REG_VP_SIZE = 3'd7;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic visible;
		logic clipped_range;
	} result_t;

	typedef struct packed {
		logic signed [31:0] r0;
		logic signed [31:0] r1;
		logic signed [31:0] r2;
		logic signed [31:0] t;
	} col_t;

endpackage
`default_nettype wire

FILE: rtl/point_project_to_screen.sv
// Projects world points to viewport pixel positions.
// Input beat: drive point and raise start; it is taken on any edge with busy
// low, and busy never rises, so one point may enter every cycle.
// Result beat: done is high for one cycle with result valid; the receiver
// cannot stall, so nothing is ever held back.
// Throughput is one point per cycle. The pipeline runs through the clip
// multipliers, the scale multiplier, the divider lanes, which resolve one
// quotient bit per stage over 41 stages, and the placing stages.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no point is in flight.
// Reset (arst_n low) clears the pipeline valid bits and restores the
// identity-like matrix and an empty viewport at the origin.
`default_nettype none
module point_project_to_screen (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire ppts_pkg::point_t point,
	output logic done,
	output ppts_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data
);

	localparam int NW = ppts_pkg::NUM_W;
	localparam int CW = ppts_pkg::CLIP_W;
	localparam int LL = ppts_pkg::LANE_LAT;

	logic [63:0] coef_q [0:5];
	logic [31:0] origin_q;
	logic [31:0] size_q;
	ppts_pkg::col_t col [0:2];
	logic signed [CW-1:0] clip_s2 [0:2];

	logic v_s1, v_s2, v_s3;
	logic [LL-1:0] vpipe_q;
	logic [LL-1:0] vis_q;
	logic vis_s3;
	logic signed [NW-1:0] numx_s3, numy_s3;
	logic [NW-1:0] den_s3;
	logic signed [31:0] lx, ly;
	logic sx, sy;
	logic done_q;
	ppts_pkg::result_t result_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= 64'h0001_0000_0000_0000;
			coef_q[1] <= 64'h0;
			coef_q[2] <= 64'h0000_0000_0001_0000;
			coef_q[3] <= 64'h0;
			coef_q[4] <= 64'h0;
			coef_q[5] <= 64'h0000_0000_0001_0000;
			origin_q <= 32'h0;
			size_q <= 32'h0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ppts_pkg::REG_COEF_X_FIRST: coef_q[0] <= cfg_data;
				ppts_pkg::REG_COEF_X_SECOND: coef_q[1] <= cfg_data;
				ppts_pkg::REG_COEF_Y_FIRST: coef_q[2] <= cfg_data;
				ppts_pkg::REG_COEF_Y_SECOND: coef_q[3] <= cfg_data;
				ppts_pkg::REG_COEF_W_FIRST: coef_q[4] <= cfg_data;
				ppts_pkg::REG_COEF_W_SECOND: coef_q[5] <= cfg_data;
				ppts_pkg::REG_VP_ORIGIN: origin_q <= cfg_data[31:0];
				ppts_pkg::REG_VP_SIZE: size_q <= cfg_data[31:0];
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			col[c].r0 = coef_q[2*c][63:32];
			col[c].r1 = coef_q[2*c][31:0];
			col[c].r2 = coef_q[2*c+1][63:32];
			col[c].t = coef_q[2*c+1][31:0];
		end
	end

	ppts_clip u_clip (
		.clk(clk),
		.point(point),
		.col(col),
		.clip_s2(clip_s2)
	);

	always_ff @(posedge clk) begin
		numx_s3 <= NW'(clip_s2[0]) + NW'(clip_s2[2]);
		numy_s3 <= NW'(clip_s2[2]) - NW'(clip_s2[1]);
		den_s3 <= {clip_s2[2][CW-1:0], 1'b0};
		vis_s3 <= clip_s2[2] > 0;
	end

	ppts_ratio u_ratio_x (
		.clk(clk),
		.num(numx_s3),
		.den(den_s3),
		.size(size_q[31:16]),
		.base(origin_q[31:16]),
		.value(lx),
		.sat(sx)
	);

	ppts_ratio u_ratio_y (
		.clk(clk),
		.num(numy_s3),
		.den(den_s3),
		.size(size_q[15:0]),
		.base(origin_q[15:0]),
		.value(ly),
		.sat(sy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vpipe_q <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vpipe_q <= {vpipe_q[LL-2:0], v_s3};
			done_q <= vpipe_q[LL-1];
		end
	end

	always_ff @(posedge clk) begin
		vis_q <= {vis_q[LL-2:0], vis_s3};
		result_q.visible <= vis_q[LL-1];
		result_q.screen_x <= vis_q[LL-1] ? lx : 32'sd0;
		result_q.screen_y <= vis_q[LL-1] ? ly : 32'sd0;
		result_q.clipped_range <= vis_q[LL-1] && (sx || sy);
	end

endmodule
`default_nettype wire

FILE: rtl/ppts_clip.sv
`default_nettype none
module ppts_clip (
	input wire logic clk,
	input wire ppts_pkg::point_t point,
	input wire ppts_pkg::col_t col [0:2],
	output logic signed [ppts_pkg::CLIP_W-1:0] clip_s2 [0:2]
);

	logic signed [47:0] prod_s1 [0:2][0:2];
	logic signed [31:0] trans_s1 [0:2];
	logic signed [47:0] prod_c [0:2][0:2];
	logic signed [63:0] full_c [0:2][0:2];
	logic signed [31:0] coord [0:2];
	logic signed [31:0] coef [0:2][0:2];

	always_comb begin
		coord[0] = point.world_x;
		coord[1] = point.world_y;
		coord[2] = point.world_z;
		for (int c = 0; c < 3; c++) begin
			coef[c][0] = col[c].r0;
			coef[c][1] = col[c].r1;
			coef[c][2] = col[c].r2;
			for (int j = 0; j < 3; j++) begin
				full_c[c][j] = coord[j] * coef[c][j];
				prod_c[c][j] = full_c[c][j][63:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			trans_s1[c] <= col[c].t;
			for (int j = 0; j < 3; j++) begin
				prod_s1[c][j] <= prod_c[c][j];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			clip_s2[c] <= ppts_pkg::CLIP_W'(prod_s1[c][0]) + ppts_pkg::CLIP_W'(prod_s1[c][1])
				+ ppts_pkg::CLIP_W'(prod_s1[c][2]) + ppts_pkg::CLIP_W'(trans_s1[c]);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ppts_ratio.sv
`default_nettype none
module ppts_ratio (
	input wire logic clk,
	input wire logic signed [ppts_pkg::NUM_W-1:0] num,
	input wire logic [ppts_pkg::NUM_W-1:0] den,
	input wire logic [15:0] size,
	input wire logic [15:0] base,
	output logic signed [31:0] value,
	output logic sat
);

	localparam int NW = ppts_pkg::NUM_W;
	localparam int PW = ppts_pkg::PROD_W;
	localparam int DB = ppts_pkg::DIV_BITS;
	localparam int NTOT = PW + 16;

	logic [NW-1:0] mag_sa;
	logic neg_sa;
	logic [NW-1:0] den_sa;

	logic [PW-1:0] prod_sb;
	logic neg_sb;
	logic [NW-1:0] den_sb;

	logic [NW-1:0] rem_d [0:DB];
	logic [DB-1:0] q_d [0:DB];
	logic [DB-1:0] nlo_d [0:DB];
	logic [NW-1:0] den_d [0:DB];
	logic neg_d [0:DB];
	logic big_d [0:DB];

	logic signed [DB:0] off_se;
	logic signed [42:0] place_c;
	logic [NTOT-1:0] dividend;
	logic [NTOT-DB-1:0] top_part;
	logic capped;
	logic [DB-1:0] qc;
	logic rn;

	always_ff @(posedge clk) begin
		neg_sa <= num[NW-1];
		mag_sa <= num[NW-1] ? NW'(-num) : NW'(num);
		den_sa <= den;
	end

	always_ff @(posedge clk) begin
		prod_sb <= PW'(mag_sa) * PW'(size);
		neg_sb <= neg_sa;
		den_sb <= den_sa;
	end

	always_comb begin
		dividend = {prod_sb, 16'b0};
		top_part = dividend[NTOT-1:DB];
	end

	always_ff @(posedge clk) begin
		big_d[0] <= NW'(top_part) >= den_sb;
		rem_d[0] <= (NW'(top_part) >= den_sb) ? '0 : NW'(top_part);
		nlo_d[0] <= dividend[DB-1:0];
		q_d[0] <= '0;
		den_d[0] <= den_sb;
		neg_d[0] <= neg_sb;
	end

	for (genvar k = 0; k < DB; k++) begin : g_step
		logic [NW:0] trial;
		logic ge;
		always_comb begin
			trial = {rem_d[k], nlo_d[k][DB-1-k]};
			ge = trial >= {1'b0, den_d[k]};
		end
		always_ff @(posedge clk) begin
			rem_d[k+1] <= ge ? NW'(trial - {1'b0, den_d[k]}) : NW'(trial);
			q_d[k+1] <= {q_d[k][DB-2:0], ge};
			nlo_d[k+1] <= nlo_d[k];
			den_d[k+1] <= den_d[k];
			neg_d[k+1] <= neg_d[k];
			big_d[k+1] <= big_d[k];
		end
	end

	always_comb begin
		capped = big_d[DB] || (q_d[DB][DB-1] && (q_d[DB][DB-2:0] != '0));
		qc = capped ? {1'b1, {(DB-1){1'b0}}} : q_d[DB];
		rn = !capped && (rem_d[DB] != '0);
	end

	always_ff @(posedge clk) begin
		if (!neg_d[DB]) begin
			off_se <= $signed({1'b0, qc});
		end else if (rn) begin
			off_se <= $signed(~{1'b0, qc});
		end else begin
			off_se <= -$signed({1'b0, qc});
		end
	end

	always_comb begin
		place_c = $signed({11'b0, base, 16'b0}) + 43'(off_se);
	end

	always_ff @(posedge clk) begin
		if (place_c > 43'sh7FFFFFFF) begin
			value <= 32'sh7FFFFFFF;
			sat <= 1'b1;
		end else if (place_c < -43'sh80000000) begin
			value <= 32'sh80000000;
			sat <= 1'b1;
		end else begin
			value <= place_c[31:0];
			sat <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb_point_project_to_screen.sv
`default_nettype none
module tb_point_project_to_screen;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 50;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ppts_pkg::point_t point = '0;
	logic done;
	ppts_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = ppts_pkg::REG_COEF_X_FIRST;
	logic [63:0] cfg_data = '0;

	logic [63:0] regs [8];
	ppts_pkg::result_t pending_screen [$];
	int errors = 0;
	int cycles = 0;

	point_project_to_screen uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_point_project_to_screen: FAIL");
			$finish;
		end
	end

	function automatic longint scaled_mul(longint a, logic [31:0] coef);
		longint p;
		p = a * longint'($signed(coef));
		return p >>> 16;
	endfunction

	function automatic longint clip_value(logic [63:0] first, logic [63:0] second,
			ppts_pkg::point_t p);
		return scaled_mul(longint'(p.world_x), first[63:32])
			+ scaled_mul(longint'(p.world_y), first[31:0])
			+ scaled_mul(longint'(p.world_z), second[63:32])
			+ longint'($signed(second[31:0]));
	endfunction

	function automatic longint pixel_offset(longint num, logic [15:0] size, longint cw);
		logic [127:0] mag, prod, den, q, r;
		bit neg;
		neg = num < 0;
		mag = neg ? 128'(-num) : 128'(num);
		prod = mag * (128'(size) << 16);
		den = 128'(cw) * 2;
		q = prod / den;
		r = prod % den;
		if (q > (128'd1 << 40)) begin
			q = 128'd1 << 40;
			r = 0;
		end
		if (neg)
			return -(longint'(q[63:0]) + (r != 0 ? 64'sd1 : 64'sd0));
		return longint'(q[63:0]);
	endfunction

	function automatic logic [31:0] place_pixel(logic [15:0] base, longint offset, ref bit sat);
		longint v;
		v = (longint'(base) << 16) + offset;
		if (v > 64'sh7FFFFFFF) begin
			v = 64'sh7FFFFFFF;
			sat = 1;
		end else if (v < -64'sh80000000) begin
			v = -64'sh80000000;
			sat = 1;
		end
		return v[31:0];
	endfunction

	function automatic ppts_pkg::result_t project_point(ppts_pkg::point_t p);
		ppts_pkg::result_t r;
		longint cx, cy, cw;
		bit sat;
		r = '0;
		sat = 0;
		cw = clip_value(regs[ppts_pkg::REG_COEF_W_FIRST], regs[ppts_pkg::REG_COEF_W_SECOND], p);
		if (cw <= 0)
			return r;
		cx = clip_value(regs[ppts_pkg::REG_COEF_X_FIRST], regs[ppts_pkg::REG_COEF_X_SECOND], p);
		cy = clip_value(regs[ppts_pkg::REG_COEF_Y_FIRST], regs[ppts_pkg::REG_COEF_Y_SECOND], p);
		r.screen_x = place_pixel(regs[ppts_pkg::REG_VP_ORIGIN][31:16],
			pixel_offset(cx + cw, regs[ppts_pkg::REG_VP_SIZE][31:16], cw), sat);
		r.screen_y = place_pixel(regs[ppts_pkg::REG_VP_ORIGIN][15:0],
			pixel_offset(cw - cy, regs[ppts_pkg::REG_VP_SIZE][15:0], cw), sat);
		r.visible = 1'b1;
		r.clipped_range = sat;
		return r;
	endfunction

	always @(posedge clk) begin
		ppts_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_screen.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				want = pending_screen.pop_front();
				if (result.screen_x !== want.screen_x) begin
					$error("screen_x expected %h actual %h", want.screen_x, result.screen_x);
					errors++;
				end
				if (result.screen_y !== want.screen_y) begin
					$error("screen_y expected %h actual %h", want.screen_y, result.screen_y);
					errors++;
				end
				if (result.visible !== want.visible) begin
					$error("visible expected %b actual %b", want.visible, result.visible);
					errors++;
				end
				if (result.clipped_range !== want.clipped_range) begin
					$error("clipped_range expected %b actual %b",
						want.clipped_range, result.clipped_range);
					errors++;
				end
			end
		end
	end

	task automatic send_point(ppts_pkg::point_t p);
		@(negedge clk);
		start = 1'b1;
		point = p;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_screen.push_back(project_point(p));
	endtask

	task automatic hold_off(int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		hold_off(0);
		while (pending_screen.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		regs[idx] = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] coord(bit wide);
		if (wide || $urandom_range(0, 9) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 32 * 65536)) - 16 * 65536);
	endfunction

	function automatic ppts_pkg::point_t random_point(bit wide, bit ahead);
		ppts_pkg::point_t p;
		p.world_x = coord(wide);
		p.world_y = coord(wide);
		p.world_z = coord(wide);
		if (ahead && !wide)
			p.world_z = -$signed(32'($urandom_range(1, 64 * 65536)));
		return p;
	endfunction

	task automatic send_stream(int n, bit wide);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && n > 0) begin
				send_point(random_point(wide, $urandom_range(0, 7) != 0));
				burst--;
				n--;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 6));
		end
		drain();
	endtask

	task automatic set_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] left_top,
			logic [31:0] size);
		write_reg(ppts_pkg::REG_COEF_X_FIRST, {fx, 32'd0});
		write_reg(ppts_pkg::REG_COEF_X_SECOND, 64'd0);
		write_reg(ppts_pkg::REG_COEF_Y_FIRST, {32'd0, fy});
		write_reg(ppts_pkg::REG_COEF_Y_SECOND, 64'd0);
		write_reg(ppts_pkg::REG_COEF_W_FIRST, 64'd0);
		write_reg(ppts_pkg::REG_COEF_W_SECOND, {32'hFFFF0000, 32'd0});
		write_reg(ppts_pkg::REG_VP_ORIGIN, left_top);
		write_reg(ppts_pkg::REG_VP_SIZE, size);
	endtask

	task automatic test_reset_values();
		send_point('{world_x: 32'sd0, world_y: 32'sd0, world_z: 32'sd0});
		send_point('{world_x: 32'sh7FFFFFFF, world_y: 32'sh80000000, world_z: 32'sd5});
		send_point('{world_x: 32'sh80000000, world_y: 32'sh7FFFFFFF, world_z: -32'sd1});
		drain();
	endtask

	task automatic test_directed();
		set_camera(32'h00010000, 32'h00010000, {16'd10, 16'd20}, {16'd640, 16'd480});
		send_point('{world_x: 32'sd0, world_y: 32'sd0, world_z: -32'sd65536});
		send_point('{world_x: 32'sd65536, world_y: 32'sd65536, world_z: -32'sd65536});
		send_point('{world_x: -32'sd65536, world_y: -32'sd65536, world_z: -32'sd65536});
		send_point('{world_x: 32'sd0, world_y: 32'sd0, world_z: 32'sd0});
		send_point('{world_x: 32'sd0, world_y: 32'sd0, world_z: 32'sd65536});
		send_point('{world_x: 32'sd0, world_y: 32'sd0, world_z: -32'sd1});
		send_point('{world_x: 32'sh7FFFFFFF, world_y: 32'sh80000000, world_z: -32'sd1});
		send_point('{world_x: 32'sh80000000, world_y: 32'sh7FFFFFFF, world_z: -32'sd1});
		send_point('{world_x: 32'sh7FFFFFFF, world_y: 32'sh7FFFFFFF, world_z: 32'sh80000000});
		send_point('{world_x: 32'sh80000000, world_y: 32'sh80000000, world_z: 32'sh80000000});
		send_point('{world_x: 32'sd3, world_y: -32'sd3, world_z: 32'sh80000000});
		drain();
		write_reg(ppts_pkg::REG_VP_SIZE, {16'd0, 16'hFFFF});
		write_reg(ppts_pkg::REG_VP_ORIGIN, 32'hFFFFFFFF);
		send_point('{world_x: 32'sd65536, world_y: -32'sd65536, world_z: -32'sd131072});
		send_point('{world_x: 32'sd0, world_y: 32'sd0, world_z: -32'sd1});
		write_reg(ppts_pkg::REG_VP_SIZE, 32'hFFFF0000);
		send_point('{world_x: -32'sd65536, world_y: 32'sd65536, world_z: -32'sd131072});
		send_point('{world_x: 32'sh7FFFFFFF, world_y: 32'sd0, world_z: -32'sd1});
		drain();
	endtask

	task automatic test_matrix_extremes();
		int k;
		for (k = 0; k < 6; k++)
			write_reg(3'(k), 64'hFFFFFFFF_FFFFFFFF);
		write_reg(ppts_pkg::REG_VP_ORIGIN, 32'hFFFFFFFF);
		write_reg(ppts_pkg::REG_VP_SIZE, 32'hFFFFFFFF);
		send_stream(40, 1'b1);
		for (k = 0; k < 6; k++)
			write_reg(3'(k), {32'h80000000, 32'h7FFFFFFF});
		write_reg(ppts_pkg::REG_VP_ORIGIN, 32'd0);
		send_stream(40, 1'b1);
		for (k = 0; k < 6; k++)
			write_reg(3'(k), {32'h7FFFFFFF, 32'h80000000});
		send_stream(40, 1'b1);
	endtask

	task automatic test_random_matrices();
		int s, k;
		for (s = 0; s < 6; s++) begin
			for (k = 0; k < 8; k++)
				write_reg(3'(k), {$urandom, $urandom});
			send_stream(60, $urandom_range(0, 1));
		end
	endtask

	task automatic test_camera_stream();
		int s;
		for (s = 0; s < 5; s++) begin
			set_camera(32'($urandom_range(16384, 4 * 65536)), 32'($urandom_range(16384, 4 * 65536)),
				$urandom, {16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096))});
			send_stream(240, 1'b0);
		end
	endtask

	initial begin
		regs[ppts_pkg::REG_COEF_X_FIRST] = 64'h00010000_00000000;
		regs[ppts_pkg::REG_COEF_X_SECOND] = 64'd0;
		regs[ppts_pkg::REG_COEF_Y_FIRST] = 64'h00000000_00010000;
		regs[ppts_pkg::REG_COEF_Y_SECOND] = 64'd0;
		regs[ppts_pkg::REG_COEF_W_FIRST] = 64'd0;
		regs[ppts_pkg::REG_COEF_W_SECOND] = 64'h00000000_00010000;
		regs[ppts_pkg::REG_VP_ORIGIN] = 64'd0;
		regs[ppts_pkg::REG_VP_SIZE] = 64'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_values();
		test_directed();
		test_matrix_extremes();
		test_random_matrices();
		test_camera_stream();
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && pending_screen.size() == 0)
			$display("tb_point_project_to_screen: PASS");
		else
			$display("tb_point_project_to_screen: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
